// ===== hdl/rda_pkg.sv =====
// ----------------------------------------------------------------------------
// rda_pkg: shared types and codes for the register descriptor allocator
// Request and action codes, sequencer states and the cell interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package rda_pkg;

    localparam int VAR_W  = 8;
    localparam int REG_W  = 4;
    localparam int RANK_W = 4;
    localparam int MODE_W = 3;
    localparam int ACT_W  = 2;

    // request modes
    localparam logic [MODE_W-1:0] MODE_USE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PAIR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DEF   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INACT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_GET   = 3'd4;

    // emitted actions
    localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_STORE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MOVE   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_ANSWER = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_CHOOSE,
        ST_PAIR,
        ST_EVICT,
        ST_LINK,
        ST_POST,
        ST_ANSWER
    } state_t;

    // broadcast to every cell
    typedef struct packed {
        logic              set_act_a;
        logic              set_act_b;
        logic              clr_act_a;
        logic              clr_clean_a;
        logic              evict;
        logic              write;
        logic [VAR_W-1:0]  var_a;
        logic [VAR_W-1:0]  var_b;
        logic [VAR_W-1:0]  ev_owner;
        logic [RANK_W-1:0] ev_rank;
        logic [VAR_W-1:0]  wr_owner;
        logic [RANK_W-1:0] wr_rank;
        logic              wr_active;
        logic              wr_clean;
    } cell_cmd_t;

    typedef struct packed {
        logic              valid;
        logic [VAR_W-1:0]  owner;
        logic [RANK_W-1:0] rank;
        logic              active;
        logic              clean;
    } cell_stat_t;

    // victim search, passed from cell to cell
    typedef struct packed {
        logic             found;
        logic             n;
        logic [REG_W-1:0] idx;
    } vict_t;

endpackage

`default_nettype wire

// ===== hdl/rda_cell.sv =====
// ----------------------------------------------------------------------------
// rda_cell: one register descriptor
// Holds owner, link rank and the owner's flags; adds itself to the victim search.
// ----------------------------------------------------------------------------
`default_nettype none

module rda_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rda_pkg::cell_cmd_t cmd,
    input  wire logic               sel,
    input  wire logic               excl_en,
    input  wire logic [7:0]         excl_var,
    input  wire rda_pkg::vict_t     vict_in,
    output rda_pkg::vict_t          vict_out,
    output rda_pkg::cell_stat_t     stat
);

    logic                        valid_reg, valid_next;
    logic [rda_pkg::VAR_W-1:0]   owner_reg, owner_next;
    logic [rda_pkg::RANK_W-1:0]  rank_reg, rank_next;
    logic                        active_reg, active_next;
    logic                        clean_reg, clean_next;
    logic                        hold_a, hold_b, excluded, ns;

    assign hold_a   = valid_reg && (owner_reg == cmd.var_a);
    assign hold_b   = valid_reg && (owner_reg == cmd.var_b);
    assign excluded = excl_en && valid_reg && (owner_reg == excl_var);
    assign ns       = valid_reg && active_reg && !clean_reg;

    always_comb
    begin
        vict_out = vict_in;
        if (!excluded && (!vict_in.found || (vict_in.n && !ns)))
        begin
            vict_out.found = 1'b1;
            vict_out.n     = ns;
            vict_out.idx   = rda_pkg::REG_W'(CELL_IDX);
        end
    end

    always_comb
    begin
        valid_next  = valid_reg;
        owner_next  = owner_reg;
        rank_next   = rank_reg;
        active_next = active_reg;
        clean_next  = clean_reg;
        if ((cmd.set_act_a && hold_a) || (cmd.set_act_b && hold_b))
            active_next = 1'b1;
        if (cmd.clr_act_a && hold_a)
            active_next = 1'b0;
        if (cmd.clr_clean_a && hold_a)
            clean_next = 1'b0;
        if (cmd.evict)
        begin
            if (sel)
                valid_next = 1'b0;
            else if (valid_reg && owner_reg == cmd.ev_owner && rank_reg > cmd.ev_rank)
                rank_next = rank_reg - 1'b1;
        end
        if (cmd.write && sel)
        begin
            valid_next  = 1'b1;
            owner_next  = cmd.wr_owner;
            rank_next   = cmd.wr_rank;
            active_next = cmd.wr_active;
            clean_next  = cmd.wr_clean;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        owner_reg  <= owner_next;
        rank_reg   <= rank_next;
        active_reg <= active_next;
        clean_reg  <= clean_next;
    end

    assign stat.valid  = valid_reg;
    assign stat.owner  = owner_reg;
    assign stat.rank   = rank_reg;
    assign stat.active = active_reg;
    assign stat.clean  = clean_reg;

endmodule

`default_nettype wire

// ===== hdl/register_descriptor_allocator.sv =====
// ----------------------------------------------------------------------------
// register_descriptor_allocator: register descriptor map with spill/fill actions
// A row of descriptor cells, one per register, driven by a request sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request item: tuser = mode, tdata = var_first, var_second.
//   m_axis carries action items: tuser = action, tdata = var_id, reg_first,
//   reg_second; tlast marks the final action of a request.
//   The sequencer emits at most one action per cycle; that sets the rate.
//   Variable flags are kept in the cells beside each owner, so there is no
//   per-variable memory and no clearing pass: reset just empties the cells.
//   A stalled m_axis holds the output register and the sequencer waits on it;
//   s_axis_tready is high only while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module register_descriptor_allocator #(
    parameter int NUM_REGS = 3,
    parameter int NUM_VARS = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [7:0] var_first, [15:8] var_second
    input  wire logic [2:0]  s_axis_tuser,   // [2:0] mode
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [15:0] m_axis_tdata,   // [7:0] var_id, [11:8] reg_first, [15:12] reg_second
    output      logic [1:0]  m_axis_tuser,   // [1:0] action
    output      logic        m_axis_tlast
);

    localparam int RIW = $clog2(NUM_REGS);
    localparam int CW  = $clog2(NUM_REGS + 1);

    rda_pkg::state_t              state_reg, state_next;
    logic [rda_pkg::MODE_W-1:0]   mode_reg, mode_next;
    logic [7:0]                   a_reg, a_next;
    logic [7:0]                   b_reg, b_next;
    logic [7:0]                   cur_v_reg, cur_v_next;
    logic [RIW-1:0]               cur_r_reg, cur_r_next;
    logic [7:0]                   placed_reg, placed_next;
    logic [7:0]                   other_reg, other_next;
    logic                         pend_reg, pend_next;

    logic                         ov_reg, ov_next;
    logic [rda_pkg::ACT_W-1:0]    oact_reg, oact_next;
    logic [7:0]                   ovar_reg, ovar_next;
    logic [rda_pkg::REG_W-1:0]    or1_reg, or1_next;
    logic [rda_pkg::REG_W-1:0]    or2_reg, or2_next;
    logic                         olast_reg, olast_next;

    rda_pkg::cell_cmd_t           cmd;
    rda_pkg::cell_stat_t          stat [NUM_REGS];
    rda_pkg::vict_t               chain [NUM_REGS+1];
    logic [NUM_REGS-1:0]          sel_vec;
    logic                         excl_en;

    logic [NUM_REGS-1:0]          hold_a, hold_b, hold_v, hold_o, hold_p;
    logic [CW-1:0]                cnt_a, cnt_b, cnt_v, cnt_o, cnt_p;
    logic [RIW-1:0]               front_v, front_a, vict;
    logic                         slot_free, accept, store_need;
    rda_pkg::cell_stat_t          cur_stat;

    // reduce a variable number into range, one conditional subtract per bit
    function automatic logic [7:0] var_mod(input logic [7:0] v);
        logic [16:0] rem;
        logic [16:0] dv;
        rem = {9'd0, v};
        if (NUM_VARS < 256)
        begin
            for (int k = 7; k >= 0; k--)
            begin
                dv = 17'(NUM_VARS) << k;
                if (rem >= dv)
                    rem = rem - dv;
            end
        end
        return rem[7:0];
    endfunction

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign slot_free = !ov_reg || m_axis_tready;

    // ---- cell row ----------------------------------------------------------
    assign chain[0] = '0;

    for (genvar i = 0; i < NUM_REGS; i++)
    begin : g_cell
        rda_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .sel      (sel_vec[i]),
            .excl_en  (excl_en),
            .excl_var (placed_reg),
            .vict_in  (chain[i]),
            .vict_out (chain[i+1]),
            .stat     (stat[i])
        );
        assign hold_a[i] = stat[i].valid && stat[i].owner == a_reg;
        assign hold_b[i] = stat[i].valid && stat[i].owner == b_reg;
        assign hold_v[i] = stat[i].valid && stat[i].owner == cur_v_reg;
        assign hold_o[i] = stat[i].valid && stat[i].owner == cur_stat.owner;
        assign hold_p[i] = stat[i].valid && stat[i].owner == placed_reg;
    end

    assign cnt_a    = CW'($countones(hold_a));
    assign cnt_b    = CW'($countones(hold_b));
    assign cnt_v    = CW'($countones(hold_v));
    assign cnt_o    = CW'($countones(hold_o));
    assign cnt_p    = CW'($countones(hold_p));
    assign cur_stat = stat[cur_r_reg];
    assign vict     = chain[NUM_REGS].idx[RIW-1:0];
    assign excl_en  = (state_reg == rda_pkg::ST_PAIR) && (cnt_p < CW'(2));

    assign store_need = cur_stat.valid && cnt_o == CW'(1) && cur_stat.active && !cur_stat.clean;

    // front register of a variable: lowest link rank among its holders
    always_comb
    begin
        logic [rda_pkg::RANK_W-1:0] bv, ba;
        logic                       fv, fa;
        bv = '0;
        ba = '0;
        fv = 1'b0;
        fa = 1'b0;
        front_v = '0;
        front_a = '0;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            if (hold_v[i] && (!fv || stat[i].rank < bv))
            begin
                fv = 1'b1;
                bv = stat[i].rank;
                front_v = RIW'(i);
            end
            if (hold_a[i] && (!fa || stat[i].rank < ba))
            begin
                fa = 1'b1;
                ba = stat[i].rank;
                front_a = RIW'(i);
            end
        end
    end

    // ---- sequencer: next state ---------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rda_pkg::ST_IDLE:
                if (accept)
                    state_next = rda_pkg::ST_START;
            rda_pkg::ST_START:
                case (mode_reg)
                    rda_pkg::MODE_USE, rda_pkg::MODE_PAIR,
                    rda_pkg::MODE_DEF, rda_pkg::MODE_GET:
                        state_next = rda_pkg::ST_CHOOSE;
                    default:
                        state_next = rda_pkg::ST_IDLE;
                endcase
            rda_pkg::ST_CHOOSE:
                case (mode_reg)
                    rda_pkg::MODE_USE:
                        state_next = (cnt_a == '0) ? rda_pkg::ST_EVICT : rda_pkg::ST_IDLE;
                    rda_pkg::MODE_DEF:
                        state_next = (cnt_a == '0) ? rda_pkg::ST_EVICT : rda_pkg::ST_POST;
                    rda_pkg::MODE_GET:
                        state_next = (cnt_a == '0) ? rda_pkg::ST_EVICT : rda_pkg::ST_ANSWER;
                    rda_pkg::MODE_PAIR:
                        if (cnt_a != '0 && cnt_b != '0)
                            state_next = rda_pkg::ST_IDLE;
                        else if (cnt_a == '0 && cnt_b == '0)
                            state_next = rda_pkg::ST_EVICT;
                        else
                            state_next = rda_pkg::ST_PAIR;
                    default:
                        state_next = rda_pkg::ST_IDLE;
                endcase
            rda_pkg::ST_PAIR:
                state_next = rda_pkg::ST_EVICT;
            rda_pkg::ST_EVICT:
                if (!store_need || slot_free)
                    state_next = rda_pkg::ST_LINK;
            rda_pkg::ST_LINK:
                if (slot_free)
                begin
                    if (pend_reg)
                        state_next = rda_pkg::ST_PAIR;
                    else if (mode_reg == rda_pkg::MODE_DEF)
                        state_next = rda_pkg::ST_POST;
                    else if (mode_reg == rda_pkg::MODE_GET)
                        state_next = rda_pkg::ST_ANSWER;
                    else
                        state_next = rda_pkg::ST_IDLE;
                end
            rda_pkg::ST_POST:
                state_next = rda_pkg::ST_IDLE;
            rda_pkg::ST_ANSWER:
                if (slot_free)
                    state_next = rda_pkg::ST_IDLE;
            default:
                state_next = rda_pkg::ST_IDLE;
        endcase
    end

    // ---- sequencer: outputs and datapath -----------------------------------
    always_comb
    begin
        mode_next   = mode_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        cur_v_next  = cur_v_reg;
        cur_r_next  = cur_r_reg;
        placed_next = placed_reg;
        other_next  = other_reg;
        pend_next   = pend_reg;

        ov_next    = ov_reg && !m_axis_tready;
        oact_next  = oact_reg;
        ovar_next  = ovar_reg;
        or1_next   = or1_reg;
        or2_next   = or2_reg;
        olast_next = olast_reg;

        cmd           = '0;
        cmd.var_a     = a_reg;
        cmd.var_b     = b_reg;
        cmd.ev_owner  = cur_stat.owner;
        cmd.ev_rank   = cur_stat.rank;
        cmd.wr_owner  = cur_v_reg;
        cmd.wr_rank   = rda_pkg::RANK_W'(cnt_v);
        cmd.wr_active = 1'b1;
        cmd.wr_clean  = 1'b1;
        sel_vec       = '0;
        s_axis_tready = (state_reg == rda_pkg::ST_IDLE);

        case (state_reg)
            rda_pkg::ST_IDLE:
                if (accept)
                begin
                    mode_next = s_axis_tuser;
                    a_next    = var_mod(s_axis_tdata[7:0]);
                    b_next    = var_mod(s_axis_tdata[15:8]);
                end
            rda_pkg::ST_START:
                case (mode_reg)
                    rda_pkg::MODE_USE, rda_pkg::MODE_DEF:
                        cmd.set_act_a = 1'b1;
                    rda_pkg::MODE_GET:
                        cmd.set_act_a = 1'b0;   // a placed variable keeps its flag; a load sets it
                    rda_pkg::MODE_PAIR:
                    begin
                        cmd.set_act_a = 1'b1;
                        cmd.set_act_b = 1'b1;
                    end
                    rda_pkg::MODE_INACT:
                        cmd.clr_act_a = 1'b1;
                    default:
                        cmd.set_act_a = 1'b0;
                endcase
            rda_pkg::ST_CHOOSE:
            begin
                cur_v_next = a_reg;
                cur_r_next = vict;
                pend_next  = (mode_reg == rda_pkg::MODE_PAIR);
                // placed variable: b if it sits anywhere, else a
                placed_next = (cnt_b != '0) ? b_reg : a_reg;
                other_next  = (cnt_b != '0) ? a_reg : b_reg;
            end
            rda_pkg::ST_PAIR:
            begin
                cur_v_next = other_reg;
                cur_r_next = vict;
                pend_next  = 1'b0;
            end
            rda_pkg::ST_EVICT:
                if (!store_need || slot_free)
                begin
                    if (cur_stat.valid)
                    begin
                        cmd.evict            = 1'b1;
                        sel_vec[cur_r_reg]   = 1'b1;
                    end
                    if (store_need)
                    begin
                        ov_next    = 1'b1;
                        oact_next  = rda_pkg::ACT_STORE;
                        ovar_next  = cur_stat.owner;
                        or1_next   = rda_pkg::REG_W'(cur_r_reg);
                        or2_next   = '0;
                        olast_next = 1'b0;
                    end
                end
            rda_pkg::ST_LINK:
                if (slot_free)
                begin
                    cmd.write          = 1'b1;
                    sel_vec[cur_r_reg] = 1'b1;
                    ov_next            = 1'b1;
                    ovar_next          = cur_v_reg;
                    olast_next         = !pend_reg && mode_reg != rda_pkg::MODE_GET;
                    if (cnt_v == '0)
                    begin
                        oact_next = rda_pkg::ACT_LOAD;
                        or1_next  = rda_pkg::REG_W'(cur_r_reg);
                        or2_next  = '0;
                    end
                    else
                    begin
                        // copy the variable's flags from its front register
                        cmd.wr_active = stat[front_v].active;
                        cmd.wr_clean  = stat[front_v].clean;
                        oact_next     = rda_pkg::ACT_MOVE;
                        or1_next      = rda_pkg::REG_W'(front_v);
                        or2_next      = rda_pkg::REG_W'(cur_r_reg);
                    end
                end
            rda_pkg::ST_POST:
                cmd.clr_clean_a = 1'b1;
            rda_pkg::ST_ANSWER:
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    oact_next  = rda_pkg::ACT_ANSWER;
                    ovar_next  = a_reg;
                    or1_next   = rda_pkg::REG_W'(front_a);
                    or2_next   = '0;
                    olast_next = 1'b1;
                end
            default:
                cmd.write = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rda_pkg::ST_IDLE;
            ov_reg    <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        cur_v_reg  <= cur_v_next;
        cur_r_reg  <= cur_r_next;
        placed_reg <= placed_next;
        other_reg  <= other_next;
        oact_reg   <= oact_next;
        ovar_reg   <= ovar_next;
        or1_reg    <= or1_next;
        or2_reg    <= or2_next;
        olast_reg  <= olast_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {or2_reg, or1_reg, ovar_reg};
    assign m_axis_tuser  = oact_reg;
    assign m_axis_tlast  = olast_reg;

endmodule

`default_nettype wire

// ===== test/register_descriptor_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_descriptor_allocator_tb: self-checking bench for the allocator
// Streams directed and random requests, predicts the load/store/move/answer
// items of each one and compares them in order with what the block emits.
// ----------------------------------------------------------------------------

module register_descriptor_allocator_tb;

    localparam int REGS = 3;
    localparam int VARS = 256;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [rda_pkg::MODE_W-1:0] mode;
        logic [rda_pkg::VAR_W-1:0]  va;
        logic [rda_pkg::VAR_W-1:0]  vb;
        int                         gap;
    } request_t;

    typedef struct {
        logic [rda_pkg::ACT_W-1:0] act;
        logic [rda_pkg::VAR_W-1:0] var_id;
        logic [rda_pkg::REG_W-1:0] r1;
        logic [rda_pkg::REG_W-1:0] r2;
        logic                      last;
    } action_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    request_t pending_reqs[$];
    action_t  expected_actions[$];
    int       errors = 0;
    int       accepted = 0;
    int       send_gap = 0;
    int       hold_cycles = 0;
    bit       hold_done = 0;
    int       cycles = 0;

    // predictor state: descriptor map and per-variable flags
    bit                       map_valid[REGS];
    bit [rda_pkg::VAR_W-1:0]  map_owner[REGS];
    int                       map_rank[REGS];
    bit                       var_act[VARS];
    bit                       var_cln[VARS];
    action_t                  step_out[4];
    int                       step_n;

    register_descriptor_allocator #(.NUM_REGS(REGS), .NUM_VARS(VARS)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // --- allocator prediction ---
    function automatic void put_action(logic [rda_pkg::ACT_W-1:0] a, int v, int r1, int r2);
        if (step_n < 4)
        begin
            step_out[step_n] = '{a, v[rda_pkg::VAR_W-1:0], r1[rda_pkg::REG_W-1:0],
                                 r2[rda_pkg::REG_W-1:0], 1'b0};
            step_n++;
        end
    endfunction

    function automatic bit holds(int r, int v);
        return map_valid[r] && map_owner[r] == v;
    endfunction

    function automatic int copies(int v);
        int n = 0;
        for (int r = 0; r < REGS; r++)
            if (holds(r, v))
                n++;
        return n;
    endfunction

    function automatic int front_of(int v);
        int best = 0;
        int rank = 256;
        for (int r = 0; r < REGS; r++)
            if (holds(r, v) && map_rank[r] < rank)
            begin
                rank = map_rank[r];
                best = r;
            end
        return best;
    endfunction

    function automatic int dirty(int r);
        if (!map_valid[r])
            return 0;
        return (var_act[map_owner[r]] && !var_cln[map_owner[r]]) ? 1 : 0;
    endfunction

    // lowest register with least spill cost; the partner's register is
    // skipped unless the partner sits in two or more
    function automatic int pick_victim(int keep);
        int best = 0;
        int best_n = 2;
        int nkeep = (keep >= 0) ? copies(keep) : 2;
        for (int r = 0; r < REGS; r++)
        begin
            if (nkeep < 2 && holds(r, keep))
                continue;
            if (dirty(r) < best_n)
            begin
                best_n = dirty(r);
                best = r;
            end
        end
        return best;
    endfunction

    function automatic void spill(int r);
        int o;
        if (!map_valid[r])
            return;
        o = map_owner[r];
        if (copies(o) == 1 && !var_cln[o] && var_act[o])
        begin
            var_cln[o] = 1;
            put_action(rda_pkg::ACT_STORE, o, front_of(o), 0);
        end
        for (int k = 0; k < REGS; k++)
            if (k != r && holds(k, o) && map_rank[k] > map_rank[r])
                map_rank[k]--;
        map_valid[r] = 0;
    endfunction

    function automatic void bind_reg(int v, int r);
        int n;
        if (holds(r, v))
            return;
        spill(r);
        n = copies(v);
        if (n == 0)
        begin
            var_cln[v] = 1;
            put_action(rda_pkg::ACT_LOAD, v, r, 0);
        end
        else
            put_action(rda_pkg::ACT_MOVE, v, front_of(v), r);
        map_valid[r] = 1;
        map_owner[r] = v[rda_pkg::VAR_W-1:0];
        map_rank[r] = n;
    endfunction

    function automatic void place_one(int v);
        var_act[v] = 1;
        if (copies(v) == 0)
            bind_reg(v, pick_victim(-1));
    endfunction

    function automatic void place_pair(int a, int b);
        int placed;
        int other;
        var_act[a] = 1;
        var_act[b] = 1;
        if (copies(a) > 0 && copies(b) > 0)
            return;
        if (copies(b) > 0)
        begin
            placed = b;
            other = a;
        end
        else
        begin
            placed = a;
            other = b;
        end
        if (copies(placed) == 0)
            place_one(placed);
        bind_reg(other, pick_victim(placed));
    endfunction

    function automatic void predict_actions(logic [rda_pkg::MODE_W-1:0] mode, int a, int b);
        step_n = 0;
        a = a % VARS;
        b = b % VARS;
        case (mode)
            rda_pkg::MODE_USE:   place_one(a);
            rda_pkg::MODE_PAIR:  place_pair(a, b);
            rda_pkg::MODE_DEF:
            begin
                place_one(a);
                var_cln[a] = 0;
            end
            rda_pkg::MODE_INACT: var_act[a] = 0;
            rda_pkg::MODE_GET:
            begin
                if (copies(a) == 0)
                    place_one(a);
                put_action(rda_pkg::ACT_ANSWER, a, front_of(a), 0);
            end
            default: ;
        endcase
        if (step_n > 0)
            step_out[step_n-1].last = 1'b1;
        for (int i = 0; i < step_n; i++)
            expected_actions.insert(expected_actions.size(), step_out[i]);
    endfunction

    // --- stimulus ---
    function automatic int idle_len();
        int p = $urandom_range(99);
        if (p < 65)
            return 0;
        if (p < 94)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic void add_req(logic [rda_pkg::MODE_W-1:0] m, int a, int b, int g);
        request_t q;
        q.mode = m;
        q.va = a[rda_pkg::VAR_W-1:0];
        q.vb = b[rda_pkg::VAR_W-1:0];
        q.gap = g;
        pending_reqs.insert(pending_reqs.size(), q);
    endfunction

    // mostly a small pool so registers get reused, spilled and shared
    function automatic int pick_var();
        if ($urandom_range(9) == 0)
            return $urandom_range(255);
        return $urandom_range(6) * 37 + 1;
    endfunction

    // driver: predicts on acceptance, then offers the next item after its gap
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_actions(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8]);
                accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() > 0 && pending_reqs[0].gap > 0)
                begin
                    send_gap = pending_reqs[0].gap - 1;
                    pending_reqs[0].gap = 0;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    request_t q;
                    q = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= q.mode;
                    s_axis_tdata <= {q.vb, q.va};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // one long hold-off midway so the block backs up into s_axis
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && accepted >= 150)
            begin
                hold_done <= 1'b1;
                hold_cycles <= 300;
            end
            else if (hold_cycles > 0)
                hold_cycles <= hold_cycles - 1;
        end
    end

    // monitor: checks each action item, then picks the next ready level
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_actions.size() == 0)
                begin
                    $error("unexpected action item: tuser=%0d tdata=%h", m_axis_tuser,
                           m_axis_tdata);
                    errors++;
                end
                else
                begin
                    action_t e;
                    e = expected_actions.pop_front();
                    if (m_axis_tuser !== e.act)
                    begin
                        $error("action: expected %0d, got %0d", e.act, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata[7:0] !== e.var_id)
                    begin
                        $error("var_id: expected %0d, got %0d", e.var_id, m_axis_tdata[7:0]);
                        errors++;
                    end
                    if (m_axis_tdata[11:8] !== e.r1)
                    begin
                        $error("reg_first: expected %0d, got %0d", e.r1, m_axis_tdata[11:8]);
                        errors++;
                    end
                    if (m_axis_tdata[15:12] !== e.r2)
                    begin
                        $error("reg_second: expected %0d, got %0d", e.r2,
                               m_axis_tdata[15:12]);
                        errors++;
                    end
                    if (m_axis_tlast !== e.last)
                    begin
                        $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0)
                m_axis_tready <= 1'b0;
            else if (accepted < 60 || accepted > 280)
                m_axis_tready <= 1'b1;   // stretches with no stall
            else
                m_axis_tready <= (idle_len() == 0);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        // directed: extremes, every mode, spills, moves, same-variable pair
        add_req(rda_pkg::MODE_USE, 0, 0, 0);
        add_req(rda_pkg::MODE_USE, 255, 0, 0);
        add_req(rda_pkg::MODE_DEF, 255, 0, 0);
        add_req(rda_pkg::MODE_PAIR, 1, 2, 0);
        add_req(rda_pkg::MODE_DEF, 1, 0, 0);
        add_req(rda_pkg::MODE_DEF, 2, 0, 0);
        add_req(rda_pkg::MODE_USE, 3, 0, 0);
        add_req(rda_pkg::MODE_PAIR, 4, 4, 0);
        add_req(rda_pkg::MODE_PAIR, 5, 4, 1);
        add_req(rda_pkg::MODE_DEF, 5, 0, 0);
        add_req(rda_pkg::MODE_PAIR, 6, 5, 0);
        add_req(rda_pkg::MODE_GET, 5, 0, 0);
        add_req(rda_pkg::MODE_GET, 9, 0, 0);
        add_req(rda_pkg::MODE_INACT, 9, 0, 0);
        add_req(rda_pkg::MODE_USE, 10, 0, 0);
        add_req(rda_pkg::MODE_DEF, 170, 85, 0);
        add_req(rda_pkg::MODE_PAIR, 85, 170, 2);
        add_req(3'd5, 255, 255, 0);
        add_req(3'd6, 0, 0, 0);
        add_req(3'd7, 17, 34, 0);
        add_req(rda_pkg::MODE_GET, 255, 255, 0);
        add_req(rda_pkg::MODE_PAIR, 255, 0, 0);
        add_req(rda_pkg::MODE_INACT, 170, 0, 0);
        add_req(rda_pkg::MODE_USE, 11, 0, 0);
        for (int i = 0; i < 300; i++)
        begin
            int p;
            logic [rda_pkg::MODE_W-1:0] m;
            p = $urandom_range(99);
            if (p < 3)
                m = 3'($urandom_range(7, 5));
            else if (p < 25)
                m = rda_pkg::MODE_USE;
            else if (p < 50)
                m = rda_pkg::MODE_PAIR;
            else if (p < 72)
                m = rda_pkg::MODE_DEF;
            else if (p < 84)
                m = rda_pkg::MODE_INACT;
            else
                m = rda_pkg::MODE_GET;
            add_req(m, pick_var(), ($urandom_range(7) == 0) ? $urandom_range(255)
                    : pick_var(), (i > 230) ? 0 : idle_len());
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_reqs.size() == 0 && !s_axis_tvalid && expected_actions.size() == 0);
        repeat (50) @(posedge clk);
        if (errors == 0 && expected_actions.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
